// ===== hw/rtl/round_robin_thread_scheduler_core_macros.svh =====
// assertion macros used by the checker
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication under reset
`define RRTS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication under reset
`define RRTS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== hw/rtl/rrts_pkg.sv =====
package rrts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_W        = 4;
    localparam int CNT_W       = 5;
    localparam int RATE_W      = 10;
    localparam int MS_W        = 24;
    localparam int TICK_W      = 32;
    localparam int PROD_W      = MS_W + RATE_W;
    localparam int PRODS_W     = PROD_W - 3;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SH    = 32;
    localparam int QUOT_W      = PRODS_W + RECIP_W - RECIP_SH;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 24;

    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(18);
    // floor(2^32 / 125), divide by 1000 is a shift by 3 then a divide by 125
    localparam logic [RECIP_W-1:0] RECIP_125  = RECIP_W'(34359738);
    localparam logic [6:0]         DIV_125    = 7'd125;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_KILL  = 3'd1,
        OP_YIELD = 3'd2,
        OP_WAKE  = 3'd3,
        OP_SLEEP = 3'd4,
        OP_IO    = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_FREE   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_SLEEP  = 2'd2,
        MODE_IO     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_NO_ACTIVE   = 2'd1,
        STAT_ADD_REFUSED = 2'd2,
        STAT_KILL_MISS   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_PREV = 2'd2,
        CELL_NEXT = 2'd3
    } cell_op_t;

endpackage

// ===== hw/rtl/rrts_ring_cell.sv =====
module rrts_ring_cell (
    input  logic                     aclk,
    input  rrts_pkg::cell_op_t       op,
    input  logic [rrts_pkg::ID_W-1:0] load_id,
    input  logic [rrts_pkg::ID_W-1:0] next_id,
    input  logic [rrts_pkg::ID_W-1:0] match_id,
    output logic [rrts_pkg::ID_W-1:0] id,
    output logic                     match
);
    import rrts_pkg::*;

    logic [ID_W-1:0] id_reg;

    always_ff @(posedge aclk) begin
        case (op)
            CELL_LOAD: id_reg <= load_id;
            CELL_NEXT: id_reg <= next_id;
            default: id_reg <= id_reg;
        endcase
    end

    assign id    = id_reg;
    assign match = (id_reg == match_id);
endmodule

// ===== hw/rtl/rrts_sleep_cell.sv =====
module rrts_sleep_cell (
    input  logic                       aclk,
    input  rrts_pkg::cell_op_t         op,
    input  logic [rrts_pkg::ID_W-1:0]   load_id,
    input  logic [rrts_pkg::TICK_W-1:0] load_tick,
    input  logic [rrts_pkg::ID_W-1:0]   prev_id,
    input  logic [rrts_pkg::TICK_W-1:0] prev_tick,
    input  logic [rrts_pkg::ID_W-1:0]   next_id,
    input  logic [rrts_pkg::TICK_W-1:0] next_tick,
    input  logic [rrts_pkg::TICK_W-1:0] cmp_tick,
    output logic [rrts_pkg::ID_W-1:0]   id,
    output logic [rrts_pkg::TICK_W-1:0] tick,
    output logic                       ge
);
    import rrts_pkg::*;

    logic [ID_W-1:0]   id_reg;
    logic [TICK_W-1:0] tick_reg;

    always_ff @(posedge aclk) begin
        case (op)
            CELL_LOAD: begin
                id_reg   <= load_id;
                tick_reg <= load_tick;
            end
            CELL_PREV: begin
                id_reg   <= prev_id;
                tick_reg <= prev_tick;
            end
            CELL_NEXT: begin
                id_reg   <= next_id;
                tick_reg <= next_tick;
            end
            default: begin
                id_reg   <= id_reg;
                tick_reg <= tick_reg;
            end
        endcase
    end

    assign id   = id_reg;
    assign tick = tick_reg;
    assign ge   = (tick_reg >= cmp_tick);
endmodule

// ===== hw/rtl/round_robin_thread_scheduler_core.sv =====
// Round-robin thread scheduler: one command word in, one status word out.
// The active ring and the sleep queue (kept sorted by wake tick) are rows of
// sixteen cells that shift together toward or away from their neighbors,
// so removal and sorted insert are each a single shift. Add, kill, yield,
// io block and a sleep on an empty ring go from the execute state straight
// to the result state; wake first pops the due sleepers, one pop per cycle;
// sleep of a running thread first passes through the tick conversion
// (multiply, reciprocal divide by 1000, one correction step) and the insert.
// A new command word is accepted only when the previous one has finished,
// while a finished result may still wait in the output register.
module round_robin_thread_scheduler_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rrts_pkg::RATE_W-1:0]    cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode, thread_id, sleep_ms, current_tick, zero pad
    input  logic [rrts_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // running_id, running_valid, status, active_count, woken_count, zero pad
    output logic [rrts_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_FIX, ST_INSERT, ST_WAKE, ST_RESP
    } state_t;

    state_t              state_reg;
    opcode_t             op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [MS_W-1:0]     ms_reg;
    logic [TICK_W-1:0]   now_reg;
    logic [RATE_W-1:0]   tick_rate_reg;
    logic [CNT_W-1:0]    ring_count_reg;
    logic [ID_W-1:0]     ring_pos_reg;
    logic [CNT_W-1:0]    slp_count_reg;
    mode_t               mode_reg [MAX_THREADS];
    logic                refused_reg;
    status_t             status_reg;
    logic [CNT_W-1:0]    woken_reg;
    logic                was_empty_reg;
    logic [ID_W-1:0]     run_id_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [TICK_W-1:0]   wake_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    cell_op_t          ring_op [MAX_THREADS];
    logic [ID_W-1:0]   ring_id [MAX_THREADS];
    logic              ring_match [MAX_THREADS];
    cell_op_t          slp_op [MAX_THREADS];
    logic [ID_W-1:0]   slp_id [MAX_THREADS];
    logic [TICK_W-1:0] slp_tick [MAX_THREADS];
    logic              slp_ge [MAX_THREADS];

    logic [ID_W-1:0]   cur_id;
    logic [ID_W-1:0]   kill_k;
    logic [ID_W-1:0]   ins_at;
    logic              head_due;
    logic              do_remove;
    logic              do_append;
    logic              do_pop;
    logic              do_insert;
    logic [ID_W-1:0]   rm_k;
    logic [ID_W-1:0]   app_id;
    logic [CNT_W-1:0]  rm_cnt;
    logic [ID_W-1:0]   pos_rm;
    logic [ID_W-1:0]   pos_adv;
    logic [PRODS_W+RECIP_W-1:0] est_full;
    logic [PRODS_W-1:0] rem_fix;
    logic              q_inc;
    status_t           status_out;

    genvar g;
    generate
        for (g = 0; g < MAX_THREADS; g++) begin : g_cells
            rrts_ring_cell u_ring (
                .aclk     (aclk),
                .op       (ring_op[g]),
                .load_id  (app_id),
                .next_id  ((g == MAX_THREADS - 1) ? '0 : ring_id[(g + 1) % MAX_THREADS]),
                .match_id (id_reg),
                .id       (ring_id[g]),
                .match    (ring_match[g])
            );
            rrts_sleep_cell u_sleep (
                .aclk      (aclk),
                .op        (slp_op[g]),
                .load_id   (run_id_reg),
                .load_tick (wake_reg),
                .prev_id   ((g == 0) ? '0 : slp_id[(g + MAX_THREADS - 1) % MAX_THREADS]),
                .prev_tick ((g == 0) ? '0 : slp_tick[(g + MAX_THREADS - 1) % MAX_THREADS]),
                .next_id   ((g == MAX_THREADS - 1) ? '0 : slp_id[(g + 1) % MAX_THREADS]),
                .next_tick ((g == MAX_THREADS - 1) ? '0 : slp_tick[(g + 1) % MAX_THREADS]),
                .cmp_tick  (wake_reg),
                .id        (slp_id[g]),
                .tick      (slp_tick[g]),
                .ge        (slp_ge[g])
            );
        end
    endgenerate

    assign cur_id   = ring_id[ring_pos_reg];
    assign head_due = (slp_count_reg != '0) && (slp_tick[0] <= now_reg);

    // first ring match and first sleeper not earlier than the new wake tick
    always_comb begin
        kill_k = '0;
        ins_at = slp_count_reg[ID_W-1:0];
        for (int i = MAX_THREADS - 1; i >= 0; i--) begin
            if (ring_match[i] && (CNT_W'(i) < ring_count_reg)) begin
                kill_k = ID_W'(i);
            end
            if (slp_ge[i] && (CNT_W'(i) < slp_count_reg)) begin
                ins_at = ID_W'(i);
            end
        end
    end

    always_comb begin
        do_remove = 1'b0;
        do_append = 1'b0;
        do_pop    = 1'b0;
        do_insert = 1'b0;
        rm_k      = ring_pos_reg;
        app_id    = id_reg;
        unique case (state_reg)
            ST_EXEC: begin
                case (op_reg)
                    OP_ADD: do_append = (mode_reg[id_reg] == MODE_FREE);
                    OP_KILL: begin
                        do_remove = (mode_reg[id_reg] == MODE_ACTIVE);
                        rm_k      = kill_k;
                    end
                    OP_SLEEP, OP_IO: do_remove = (ring_count_reg != '0);
                    default: ;
                endcase
            end
            ST_WAKE: begin
                do_pop    = head_due;
                do_append = head_due;
                app_id    = slp_id[0];
            end
            ST_INSERT: do_insert = 1'b1;
            default: ;
        endcase

        for (int i = 0; i < MAX_THREADS; i++) begin
            ring_op[i] = CELL_HOLD;
            slp_op[i]  = CELL_HOLD;
            if (do_remove && (ID_W'(i) >= rm_k)) begin
                ring_op[i] = CELL_NEXT;
            end
            if (do_append && (CNT_W'(i) == ring_count_reg)) begin
                ring_op[i] = CELL_LOAD;
            end
            if (do_pop) begin
                slp_op[i] = CELL_NEXT;
            end
            if (do_insert && (ID_W'(i) == ins_at)) begin
                slp_op[i] = CELL_LOAD;
            end else if (do_insert && (ID_W'(i) > ins_at)) begin
                slp_op[i] = CELL_PREV;
            end
        end
    end

    // position after removal and after one round-robin step
    always_comb begin
        rm_cnt = ring_count_reg - CNT_W'(1);
        if (rm_cnt == '0) begin
            pos_rm = '0;
        end else if (ring_pos_reg > rm_k) begin
            pos_rm = ring_pos_reg - ID_W'(1);
        end else if ((ring_pos_reg == rm_k) && ({1'b0, rm_k} >= rm_cnt)) begin
            pos_rm = '0;
        end else begin
            pos_rm = ring_pos_reg;
        end
        if ((ring_count_reg == '0) || ({1'b0, ring_pos_reg} + CNT_W'(1) == ring_count_reg)) begin
            pos_adv = '0;
        end else begin
            pos_adv = ring_pos_reg + ID_W'(1);
        end
    end

    // quotient estimate by reciprocal, low by at most one
    assign est_full = {{RECIP_W{1'b0}}, prod_reg[PROD_W-1:3]} * {{PRODS_W{1'b0}}, RECIP_125};
    assign rem_fix  = prod_reg[PROD_W-1:3] - PRODS_W'(quot_reg) * PRODS_W'(DIV_125);
    assign q_inc    = (rem_fix >= PRODS_W'(DIV_125));

    always_comb begin
        if (refused_reg) begin
            status_out = status_reg;
        end else if (ring_count_reg == '0) begin
            status_out = STAT_NO_ACTIVE;
        end else begin
            status_out = STAT_OK;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_rate_reg  <= RATE_RESET;
            ring_count_reg <= '0;
            ring_pos_reg   <= '0;
            slp_count_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++) begin
                mode_reg[i] <= MODE_FREE;
            end
        end else begin
            if (cfg_wr_en) begin
                tick_rate_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESP)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= opcode_t'(s_tdata[2:0]);
                        id_reg      <= s_tdata[6:3];
                        ms_reg      <= s_tdata[30:7];
                        now_reg     <= s_tdata[62:31];
                        refused_reg <= 1'b0;
                        woken_reg   <= '0;
                        state_reg   <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_RESP;
                    case (op_reg)
                        OP_ADD: begin
                            if (mode_reg[id_reg] != MODE_FREE) begin
                                refused_reg <= 1'b1;
                                status_reg  <= STAT_ADD_REFUSED;
                            end else begin
                                mode_reg[id_reg] <= MODE_ACTIVE;
                                ring_count_reg   <= ring_count_reg + CNT_W'(1);
                            end
                        end
                        OP_KILL: begin
                            if (mode_reg[id_reg] != MODE_ACTIVE) begin
                                refused_reg <= 1'b1;
                                status_reg  <= STAT_KILL_MISS;
                            end else begin
                                mode_reg[id_reg] <= MODE_FREE;
                                ring_count_reg   <= rm_cnt;
                                ring_pos_reg     <= pos_rm;
                            end
                        end
                        OP_YIELD: ring_pos_reg <= pos_adv;
                        OP_WAKE: begin
                            was_empty_reg <= (ring_count_reg == '0);
                            state_reg     <= ST_WAKE;
                        end
                        OP_SLEEP, OP_IO: begin
                            if (ring_count_reg != '0) begin
                                ring_count_reg <= rm_cnt;
                                ring_pos_reg   <= pos_rm;
                                run_id_reg     <= cur_id;
                                if (op_reg == OP_SLEEP) begin
                                    mode_reg[cur_id] <= MODE_SLEEP;
                                    state_reg        <= ST_MUL;
                                end else begin
                                    mode_reg[cur_id] <= MODE_IO;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                ST_MUL: begin
                    prod_reg  <= PROD_W'(ms_reg) * PROD_W'(tick_rate_reg);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    quot_reg  <= est_full[RECIP_SH +: QUOT_W];
                    state_reg <= ST_FIX;
                end
                ST_FIX: begin
                    wake_reg  <= TICK_W'(quot_reg) + now_reg + TICK_W'(q_inc);
                    state_reg <= ST_INSERT;
                end
                ST_INSERT: begin
                    slp_count_reg <= slp_count_reg + CNT_W'(1);
                    state_reg     <= ST_RESP;
                end
                ST_WAKE: begin
                    if (head_due) begin
                        mode_reg[slp_id[0]] <= MODE_ACTIVE;
                        ring_count_reg      <= ring_count_reg + CNT_W'(1);
                        slp_count_reg       <= slp_count_reg - CNT_W'(1);
                        woken_reg           <= woken_reg + CNT_W'(1);
                    end else begin
                        if (!was_empty_reg) begin
                            ring_pos_reg <= pos_adv;
                        end
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'd0, woken_reg, ring_count_reg, status_out,
                                         (ring_count_reg != '0),
                                         (ring_count_reg != '0) ? cur_id : ID_W'(0)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

// ===== hw/rtl/rrts_checker.sv =====
`include "round_robin_thread_scheduler_core_macros.svh"

module rrts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rrts_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrts_pkg::*;

    // running flag follows the ring size
    `RRTS_ASSERT_IMP(a_valid_count, aclk, aresetn, m_tvalid, (m_tdata[4] == (m_tdata[11:7] != 5'd0)))
    // empty ring shows thread zero
    `RRTS_ASSERT_IMP(a_idle_id, aclk, aresetn, m_tvalid && !m_tdata[4], m_tdata[3:0] == 4'd0)
    // ring never exceeds the thread count
    `RRTS_ASSERT_IMP(a_count_max, aclk, aresetn, m_tvalid, m_tdata[11:7] <= 5'(MAX_THREADS))
    // a word taken in produces no result in the next cycle
    `RRTS_ASSERT_NXT(a_no_same, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid)
    // stalled result holds
    `RRTS_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind round_robin_thread_scheduler_core rrts_checker u_rrts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
